[rtl/rgba_fade_interpolator_macros.svh]
// Assertion macros shared by the fade interpolator RTL.
// No dependencies; included by modules that carry assertions.
`ifndef RGBA_FADE_INTERPOLATOR_MACROS_SVH
`define RGBA_FADE_INTERPOLATOR_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define RGBAFI_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset
`define RGBAFI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/rgbafi_pkg.sv]
// Shared types, constants and helpers for the RGBA fade interpolator.
// No dependencies; imported by rgbafi_lerp and rgba_fade_interpolator.
`default_nettype none

package rgbafi_pkg;

  localparam int TimeBits    = 48;
  localparam int DurBits     = 31;
  localparam int ColorBits   = 32;
  localparam int ChanBits    = 8;
  localparam int NumChan     = ColorBits / ChanBits;
  localparam int ProdBits    = ChanBits + DurBits;
  localparam int CfgIdxBits  = 3;
  localparam int CfgDataBits = 48;

  typedef logic [TimeBits-1:0]  time_t;
  typedef logic [DurBits-1:0]   dur_t;
  typedef logic [ColorBits-1:0] color_t;
  typedef logic [ChanBits-1:0]  chan_t;

  localparam logic [1:0] ChanLast = 2'(NumChan - 1);
  localparam logic [2:0] BitLast  = 3'(ChanBits - 1);

  // Configuration register indexes
  localparam logic [CfgIdxBits-1:0] CfgStartTime = 3'd0;
  localparam logic [CfgIdxBits-1:0] CfgDuration  = 3'd1;
  localparam logic [CfgIdxBits-1:0] CfgFromColor = 3'd2;
  localparam logic [CfgIdxBits-1:0] CfgToColor   = 3'd3;
  localparam logic [CfgIdxBits-1:0] CfgPingPong  = 3'd4;

  // Top-level sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ARM,
    ST_CHK,
    ST_RUN,
    ST_DONE
  } fsm_e;

  // Interpolation unit states
  typedef enum logic [1:0] {
    LERP_IDLE,
    LERP_MUL,
    LERP_DIV
  } lerp_st_e;

  typedef struct packed {
    logic   valid;
    color_t from_color;
    color_t to_color;
    dur_t   elapsed;
    dur_t   span;
  } lerp_req_t;

  typedef struct packed {
    logic   done;
    color_t color;
  } lerp_rsp_t;

  // End time = start + duration, saturated at the time field maximum
  function automatic time_t sat_end(input time_t s, input dur_t d);
    logic [TimeBits:0] sum;
    sum = {1'b0, s} + {{(TimeBits + 1 - DurBits){1'b0}}, d};
    return sum[TimeBits] ? '1 : sum[TimeBits-1:0];
  endfunction

endpackage

`default_nettype wire

[rtl/rgbafi_lerp.sv]
// Bit-serial channel interpolator: one 8x31 product per channel, then a
// restoring divide that yields one quotient bit per cycle. Uses rgbafi_pkg.
`default_nettype none
`include "rgba_fade_interpolator_macros.svh"

module rgbafi_lerp (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  rgbafi_pkg::lerp_req_t req_i,
  output rgbafi_pkg::lerp_rsp_t rsp_o
);
  import rgbafi_pkg::*;

  lerp_st_e state_q, state_d;
  logic [1:0] ch_q, ch_d;
  logic [2:0] bit_q, bit_d;
  logic done_q, done_d;

  color_t from_sh_q, from_sh_d;
  color_t to_sh_q, to_sh_d;
  dur_t   elapsed_q, elapsed_d;
  dur_t   span_q, span_d;
  logic [ProdBits-1:0]   rem_q, rem_d;
  logic [ProdBits-2:0]   dvs_q, dvs_d;
  chan_t  quo_q, quo_d;
  logic   up_q, up_d;
  color_t res_q, res_d;

  chan_t from_b, to_b, mag, q_full, res_b;
  logic  up, ge, ch_end, last_ch;

  // Current channel digit sits in the low byte of the shift registers
  assign from_b = from_sh_q[ChanBits-1:0];
  assign to_b   = to_sh_q[ChanBits-1:0];
  assign up     = (to_b >= from_b);
  assign mag    = up ? (to_b - from_b) : (from_b - to_b);
  assign ge     = (rem_q >= {1'b0, dvs_q});
  assign q_full = {quo_q[ChanBits-2:0], ge};
  assign res_b  = up_q ? (from_b + q_full) : (from_b - q_full);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      LERP_IDLE: if (req_i.valid) state_d = LERP_MUL;
      LERP_MUL:  state_d = LERP_DIV;
      LERP_DIV: begin
        if (bit_q == '0) begin
          state_d = (ch_q == ChanLast) ? LERP_IDLE : LERP_MUL;
        end
      end
      default:   state_d = LERP_IDLE;
    endcase
  end

  // Decoded strobes
  always_comb begin
    ch_end  = (state_q == LERP_DIV) && (bit_q == '0);
    last_ch = ch_end && (ch_q == ChanLast);
  end

  // Datapath and counters
  always_comb begin
    ch_d      = ch_q;
    bit_d     = bit_q;
    done_d    = last_ch;
    from_sh_d = from_sh_q;
    to_sh_d   = to_sh_q;
    elapsed_d = elapsed_q;
    span_d    = span_q;
    rem_d     = rem_q;
    dvs_d     = dvs_q;
    quo_d     = quo_q;
    up_d      = up_q;
    res_d     = res_q;
    case (state_q)
      LERP_IDLE: begin
        if (req_i.valid) begin
          from_sh_d = req_i.from_color;
          to_sh_d   = req_i.to_color;
          elapsed_d = req_i.elapsed;
          span_d    = req_i.span;
          ch_d      = '0;
        end
      end
      LERP_MUL: begin
        // |to - from| * elapsed; divisor starts at span << 7
        rem_d = {{DurBits{1'b0}}, mag} * {{ChanBits{1'b0}}, elapsed_q};
        dvs_d = {span_q, {(ChanBits-1){1'b0}}};
        up_d  = up;
        quo_d = '0;
        bit_d = BitLast;
      end
      LERP_DIV: begin
        if (ge) rem_d = rem_q - {1'b0, dvs_q};
        quo_d = q_full;
        dvs_d = dvs_q >> 1;
        bit_d = bit_q - 3'd1;
        if (ch_end) begin
          res_d     = {res_b, res_q[ColorBits-1:ChanBits]};
          from_sh_d = from_sh_q >> ChanBits;
          to_sh_d   = to_sh_q >> ChanBits;
          ch_d      = ch_q + 2'd1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= LERP_IDLE;
      ch_q    <= '0;
      bit_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      ch_q    <= ch_d;
      bit_q   <= bit_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    from_sh_q <= from_sh_d;
    to_sh_q   <= to_sh_d;
    elapsed_q <= elapsed_d;
    span_q    <= span_d;
    rem_q     <= rem_d;
    dvs_q     <= dvs_d;
    quo_q     <= quo_d;
    up_q      <= up_d;
    res_q     <= res_d;
  end

  assign rsp_o.done  = done_q;
  assign rsp_o.color = res_q;

  `RGBAFI_ASSERT_IMPL(a_req_when_idle, clk_i, rst_ni, req_i.valid, state_q == LERP_IDLE, "lerp request while busy")
  `RGBAFI_ASSERT_IMPL(a_done_after_div, clk_i, rst_ni, done_q, $past(state_q) == LERP_DIV, "done without a final divide step")

endmodule

`default_nettype wire

[rtl/rgba_fade_interpolator.sv]
// RGBA fade interpolator top level. Uses rgbafi_pkg and rgbafi_lerp.
// One tick at a time: the next tick is taken only once the word of the last
// one is loaded into the output register. A tick that interpolates waits for
// the four channels, which share one bit-serial divider; other ticks give
// their word without it.
// Reset (async, active low) clears the config registers, the fade state and
// the sequencer and valid flags; datapath registers keep their contents.
`default_nettype none
`include "rgba_fade_interpolator_macros.svh"

module rgba_fade_interpolator (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [rgbafi_pkg::CfgIdxBits-1:0]    cfg_idx_i,
  input  logic [rgbafi_pkg::CfgDataBits-1:0]   cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [rgbafi_pkg::TimeBits-1:0]      current_time_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [rgbafi_pkg::ColorBits-1:0]     color_out_o,
  output logic                                 changed_o
);
  import rgbafi_pkg::*;

  fsm_e state_q, state_d;

  // Configuration registers
  time_t  cfg_start_q, cfg_start_d;
  dur_t   cfg_dur_q, cfg_dur_d;
  color_t cfg_from_q, cfg_from_d;
  color_t cfg_to_q, cfg_to_d;
  logic   cfg_pp_q, cfg_pp_d;

  // Fade state
  time_t  act_start_q, act_start_d;
  time_t  act_end_q, act_end_d;
  color_t act_from_q, act_from_d;
  color_t act_to_q, act_to_d;
  color_t present_q, present_d;

  // Tick in flight and output word
  time_t  t_q, t_d;
  logic   changed_q, changed_d;
  logic   out_valid_q, out_valid_d;
  color_t out_color_q, out_color_d;
  logic   out_changed_q, out_changed_d;

  lerp_req_t lerp_req;
  lerp_rsp_t lerp_rsp;

  logic   out_free, load_out;
  logic   chk_active, chk_late, cfg_hit;
  logic   pp_from_hit, pp_swap;
  color_t pp_p1;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign chk_active = (act_start_q <= t_q) && (act_start_q != act_end_q);
  assign chk_late   = (t_q > act_end_q);

  // Ping-pong checks: same direction first, then reversed
  assign pp_from_hit = (present_q == act_from_q);
  assign pp_p1       = (pp_from_hit && (cfg_dur_q == '0)) ? act_to_q : present_q;
  assign pp_swap     = (pp_p1 == act_to_q);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_ARM;
      ST_ARM:  state_d = ST_CHK;
      ST_CHK:  state_d = (chk_active && !chk_late) ? ST_RUN : ST_DONE;
      ST_RUN:  if (lerp_rsp.done) state_d = ST_DONE;
      ST_DONE: if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Handshake and unit strobes
  always_comb begin
    in_stall_o          = (state_q != ST_IDLE);
    load_out            = (state_q == ST_DONE) && out_free;
    lerp_req.valid      = (state_q == ST_CHK) && chk_active && !chk_late;
    lerp_req.from_color = act_from_q;
    lerp_req.to_color   = act_to_q;
    lerp_req.elapsed    = t_q[DurBits-1:0] - act_start_q[DurBits-1:0];
    lerp_req.span       = act_end_q[DurBits-1:0] - act_start_q[DurBits-1:0];
  end

  // Configuration, fade state and output word
  always_comb begin
    cfg_start_d   = cfg_start_q;
    cfg_dur_d     = cfg_dur_q;
    cfg_from_d    = cfg_from_q;
    cfg_to_d      = cfg_to_q;
    cfg_pp_d      = cfg_pp_q;
    act_start_d   = act_start_q;
    act_end_d     = act_end_q;
    act_from_d    = act_from_q;
    act_to_d      = act_to_q;
    present_d     = present_q;
    t_d           = t_q;
    changed_d     = changed_q;
    cfg_hit       = 1'b0;

    if (state_q == ST_IDLE && in_valid_i) t_d = current_time_i;

    // Ping-pong re-arm of an idle fade
    if (state_q == ST_ARM && (act_start_q == act_end_q) && cfg_pp_q) begin
      if (pp_from_hit || pp_swap) begin
        act_start_d = t_q;
        act_end_d   = sat_end(t_q, cfg_dur_q);
        present_d   = pp_p1;
      end
      if (pp_swap) begin
        act_from_d = act_to_q;
        act_to_d   = act_from_q;
        if (cfg_dur_q == '0) present_d = act_from_q;
      end
    end

    // Time window checks
    if (state_q == ST_CHK) begin
      changed_d = chk_active;
      if (chk_active && chk_late) begin
        present_d   = act_to_q;
        act_start_d = act_end_q;
      end
    end

    if (state_q == ST_RUN && lerp_rsp.done) present_d = lerp_rsp.color;

    // A write to a defined register re-arms the fade from the new register set
    if (cfg_we_i) begin
      cfg_hit = 1'b1;
      case (cfg_idx_i)
        CfgStartTime: cfg_start_d = cfg_data_i[TimeBits-1:0];
        CfgDuration:  cfg_dur_d   = cfg_data_i[DurBits-1:0];
        CfgFromColor: cfg_from_d  = cfg_data_i[ColorBits-1:0];
        CfgToColor:   cfg_to_d    = cfg_data_i[ColorBits-1:0];
        CfgPingPong:  cfg_pp_d    = cfg_data_i[0];
        default:      cfg_hit     = 1'b0;
      endcase
      if (cfg_hit) begin
        act_start_d = cfg_start_d;
        act_end_d   = sat_end(cfg_start_d, cfg_dur_d);
        act_from_d  = cfg_from_d;
        act_to_d    = cfg_to_d;
        if (cfg_dur_d == '0) present_d = cfg_to_d;
      end
    end
  end

  // Output register
  always_comb begin
    out_valid_d   = out_valid_q && out_stall_i;
    out_color_d   = out_color_q;
    out_changed_d = out_changed_q;
    if (load_out) begin
      out_valid_d   = 1'b1;
      out_color_d   = present_q;
      out_changed_d = changed_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cfg_start_q <= '0;
      cfg_dur_q   <= '0;
      cfg_from_q  <= '0;
      cfg_to_q    <= '0;
      cfg_pp_q    <= 1'b0;
      act_start_q <= '0;
      act_end_q   <= '0;
      act_from_q  <= '0;
      act_to_q    <= '0;
      present_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cfg_start_q <= cfg_start_d;
      cfg_dur_q   <= cfg_dur_d;
      cfg_from_q  <= cfg_from_d;
      cfg_to_q    <= cfg_to_d;
      cfg_pp_q    <= cfg_pp_d;
      act_start_q <= act_start_d;
      act_end_q   <= act_end_d;
      act_from_q  <= act_from_d;
      act_to_q    <= act_to_d;
      present_q   <= present_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    t_q           <= t_d;
    changed_q     <= changed_d;
    out_color_q   <= out_color_d;
    out_changed_q <= out_changed_d;
  end

  rgbafi_lerp u_lerp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (lerp_req),
    .rsp_o  (lerp_rsp)
  );

  assign out_valid_o = out_valid_q;
  assign color_out_o = out_color_q;
  assign changed_o   = out_changed_q;

  `RGBAFI_ASSERT_IMPL(a_out_from_done, clk_i, rst_ni, $rose(out_valid_q), $past(state_q) == ST_DONE, "output word loaded outside DONE")
  `RGBAFI_ASSERT_NEXT(a_late_goes_idle, clk_i, rst_ni, (state_q == ST_CHK) && chk_active && chk_late && !cfg_we_i, act_start_q == act_end_q, "fade not idle after end time")

endmodule

`default_nettype wire

[tb/testbench.sv]
// Self-checking testbench for rgba_fade_interpolator: sends time ticks, predicts each
// color word in step with the block and compares them field by field.
// Depends on rgbafi_pkg and the RTL of the block only.
module testbench;
  import rgbafi_pkg::*;

  localparam int    HalfPeriod = 6;
  localparam int    CycleLimit = 500000;
  localparam time_t TimeMax    = '1;
  localparam logic [CfgIdxBits-1:0] CfgFirstUnused = CfgPingPong + 3'd1;
  localparam logic [CfgIdxBits-1:0] CfgLastIdx     = '1;

  typedef struct packed {
    color_t color;
    logic   changed;
  } fade_word_t;

  // DUT connections
  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [CfgIdxBits-1:0]  cfg_idx_i;
  logic [CfgDataBits-1:0] cfg_data_i;
  logic                   in_valid_i;
  logic                   in_stall_o;
  time_t                  current_time_i;
  logic                   out_valid_o;
  logic                   out_stall_i;
  color_t                 color_out_o;
  logic                   changed_o;

  // Traffic shaping and bookkeeping
  int         idle_pct    = 0;
  int         stall_pct   = 0;
  int         hold_left   = 0;
  int         cycle_count = 0;
  int         mismatch_count = 0;
  fade_word_t pending_words[$];

  // Fade predictor: register copies and live fade state
  time_t  reg_start;
  dur_t   reg_dur;
  color_t reg_from;
  color_t reg_to;
  logic   reg_pingpong;
  time_t  cur_start;
  time_t  cur_end;
  color_t cur_from;
  color_t cur_to;
  color_t shown_color;

  rgba_fade_interpolator dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .current_time_i (current_time_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .color_out_o    (color_out_o),
    .changed_o      (changed_o)
  );

  always #(HalfPeriod) clk_i = ~clk_i;

  // Load a fade; end time is start plus duration, clamped at the time maximum
  function automatic void rearm(time_t s, color_t f, color_t t, dur_t d);
    logic [TimeBits:0] sum;
    sum = {1'b0, s} + {{(TimeBits + 1 - DurBits){1'b0}}, d};
    cur_start = s;
    cur_end   = sum[TimeBits] ? TimeMax : sum[TimeBits-1:0];
    cur_from  = f;
    cur_to    = t;
    if (d == '0) shown_color = t;
  endfunction

  // Register write as the block sees it; unused indexes leave the fade alone
  function automatic void apply_reg(logic [CfgIdxBits-1:0] idx, logic [CfgDataBits-1:0] data);
    case (idx)
      CfgStartTime: reg_start = data[TimeBits-1:0];
      CfgDuration:  reg_dur = data[DurBits-1:0];
      CfgFromColor: reg_from = data[ColorBits-1:0];
      CfgToColor:   reg_to = data[ColorBits-1:0];
      CfgPingPong:  reg_pingpong = data[0];
      default:      return;
    endcase
    rearm(reg_start, reg_from, reg_to, reg_dur);
  endfunction

  // One channel: from + trunc((to - from) * elapsed / span), exact
  function automatic chan_t blend(chan_t f, chan_t t, logic [63:0] el, logic [63:0] sp);
    logic [63:0] diff;
    logic [63:0] q;
    if (sp == '0) return t;
    if (t >= f) begin
      diff = {{(64 - ChanBits){1'b0}}, t - f};
      q = (diff * el) / sp;
      return f + chan_t'(q);
    end
    diff = {{(64 - ChanBits){1'b0}}, f - t};
    q = (diff * el) / sp;
    return f - chan_t'(q);
  endfunction

  // Expected word for one tick; advances the predictor state
  function automatic fade_word_t fade_tick(time_t t);
    fade_word_t  w;
    logic [63:0] el;
    logic [63:0] sp;
    color_t      c;
    w.changed = 1'b0;
    // ping-pong restart of an idle fade
    if (cur_start == cur_end && reg_pingpong) begin
      if (shown_color == cur_from) rearm(t, cur_from, cur_to, reg_dur);
      if (shown_color == cur_to) rearm(t, cur_to, cur_from, reg_dur);
    end
    if (cur_start <= t && cur_start != cur_end) begin
      w.changed = 1'b1;
      if (t <= cur_end) begin
        el = {{(64 - TimeBits){1'b0}}, t - cur_start};
        sp = {{(64 - TimeBits){1'b0}}, cur_end - cur_start};
        for (int i = 0; i < NumChan; i++) begin
          c[ChanBits*i +: ChanBits] = blend(cur_from[ChanBits*i +: ChanBits],
                                            cur_to[ChanBits*i +: ChanBits], el, sp);
        end
        shown_color = c;
      end else begin
        // past the end: snap and go idle
        shown_color = cur_to;
        cur_start   = cur_end;
      end
    end
    w.color = shown_color;
    return w;
  endfunction

  // Random bits above a register's width, half of the time
  function automatic logic [CfgDataBits-1:0] add_junk(logic [CfgDataBits-1:0] v, int bits);
    logic [63:0] r;
    r = {$urandom, $urandom};
    if ($urandom_range(1) == 0) return v;
    return v | CfgDataBits'(r << bits);
  endfunction

  // Config write; leaves the write enable high for a following write
  task automatic write_reg(input logic [CfgIdxBits-1:0] idx, input logic [CfgDataBits-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    apply_reg(idx, data);
  endtask

  task automatic program_fade(input time_t s, input logic [CfgDataBits-1:0] dur_word,
                              input color_t f, input color_t t, input logic pp);
    write_reg(CfgStartTime, s);
    write_reg(CfgDuration, dur_word);
    write_reg(CfgFromColor, add_junk(CfgDataBits'(f), ColorBits));
    write_reg(CfgToColor, add_junk(CfgDataBits'(t), ColorBits));
    write_reg(CfgPingPong, add_junk(CfgDataBits'(pp), 1));
    cfg_we_i <= 1'b0;
  endtask

  // Offer one tick, wait for acceptance, record the expected word
  task automatic send_tick(input time_t t);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    current_time_i <= t;
    do @(posedge clk_i); while (in_stall_o);
    pending_words.push_back(fade_tick(t));
  endtask

  // Wait until every expected word has come back and the block has settled
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic test_idle_after_reset();
    send_tick('0);
    send_tick(TimeMax);
    drain();
  endtask

  // Red rises, green falls, blue rises, alpha stays
  task automatic test_linear_fade();
    program_fade(48'd100, 48'd50, 32'h00FF_10A0, 32'hFF00_F0A0, 1'b0);
    send_tick(48'd50);
    send_tick(48'd100);
    send_tick(48'd125);
    send_tick(48'd149);
    send_tick(48'd150);
    send_tick(48'd151);
    send_tick(48'd160);
    drain();
  endtask

  // Zero duration, with set bits above the duration field
  task automatic test_zero_duration();
    program_fade(48'd200, 48'hFFFF_8000_0000, 32'h1234_5678, 32'h89AB_CDEF, 1'b0);
    send_tick(48'd100);
    send_tick(48'd300);
    drain();
  endtask

  // End time clamps at the time maximum
  task automatic test_end_saturation();
    program_fade(TimeMax - 48'd10, 48'hFFFF_FFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
    send_tick(TimeMax - 48'd11);
    send_tick(TimeMax - 48'd10);
    send_tick(TimeMax);
    drain();
  endtask

  task automatic test_ping_pong();
    program_fade(48'd1000, 48'd20, 32'h1122_3344, 32'h5566_7788, 1'b1);
    send_tick(48'd1010);
    send_tick(48'd1020);
    send_tick(48'd1025);
    send_tick(48'd1030);
    send_tick(48'd1040);
    send_tick(48'd1055);
    drain();
    // equal endpoints with zero duration: both restarts fire, nothing moves
    program_fade(48'd0, 48'd0, 32'h5A5A_5A5A, 32'h5A5A_5A5A, 1'b1);
    send_tick(48'd10);
    send_tick(48'd20);
    drain();
  endtask

  // Writes beyond the register list must not re-arm a finished fade
  task automatic test_ignored_index();
    program_fade(48'd0, 48'd100, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
    send_tick(48'd50);
    send_tick(48'd200);
    drain();
    for (int i = CfgFirstUnused; i <= CfgLastIdx; i++) begin
      write_reg(CfgIdxBits'(i), '1);
    end
    cfg_we_i <= 1'b0;
    send_tick(48'd150);
    drain();
  endtask

  // Random fades walked tick by tick, under four mixes of input idling and output stalls
  task automatic test_random_traffic();
    int          pct_idle [4] = '{0, 76, 0, 33};
    int          pct_stall[4] = '{0, 0, 76, 33};
    int          sent;
    int          n;
    int          sel;
    time_t       s;
    time_t       tk;
    dur_t        d;
    color_t      f_col;
    color_t      t_col;
    color_t      lanes;
    logic [31:0] step;
    for (int p = 0; p < 4; p++) begin
      idle_pct  = pct_idle[p];
      stall_pct = pct_stall[p];
      sent = 0;
      while (sent < 265) begin
        drain();
        // start time: mostly anywhere, some small, some at the top of the range
        sel = $urandom_range(9);
        if (sel == 0) s = TimeMax - time_t'($urandom_range(0, 500));
        else if (sel <= 3) s = time_t'($urandom_range(0, 1000));
        else s = time_t'({$urandom, $urandom});
        // duration: mostly short, some zero, some huge
        sel = $urandom_range(9);
        if (sel == 0) d = '0;
        else if (sel == 1) d = dur_t'($urandom);
        else if (sel == 2) d = dur_t'($urandom_range(1, 4));
        else d = dur_t'($urandom_range(1, 300));
        // colors: random, equal, or sharing some channels
        f_col = $urandom;
        sel = $urandom_range(4);
        lanes = {{8{$urandom_range(1) == 1}}, {8{$urandom_range(1) == 1}},
                 {8{$urandom_range(1) == 1}}, {8{$urandom_range(1) == 1}}};
        if (sel == 0) t_col = f_col;
        else if (sel == 1) t_col = (f_col & lanes) | ($urandom & ~lanes);
        else t_col = $urandom;
        if ($urandom_range(9) == 0) begin
          write_reg(CfgIdxBits'($urandom_range(CfgFirstUnused, CfgLastIdx)),
                    CfgDataBits'({$urandom, $urandom}));
        end
        program_fade(s, add_junk(CfgDataBits'(d), DurBits), f_col, t_col,
                     1'($urandom_range(1)));
        // ticks walk forward across the fade, with some stray times mixed in
        n  = $urandom_range(8, 30);
        tk = (s > 3) ? s - time_t'($urandom_range(0, 3)) : '0;
        for (int k = 0; k < n; k++) begin
          if ($urandom_range(9) == 0) begin
            send_tick(time_t'({$urandom, $urandom}));
          end else begin
            send_tick(tk);
            step = $urandom_range(0, (d / 5) + 2);
            if (TimeMax - tk < time_t'(step)) tk = TimeMax;
            else tk = tk + time_t'(step);
          end
          sent++;
        end
      end
    end
    idle_pct  = 0;
    stall_pct = 0;
    drain();
  endtask

  // Receiver holds off for a long stretch while ticks keep coming
  task automatic test_input_backpressure();
    program_fade(48'd0, 48'd100000, $urandom, $urandom, 1'b0);
    hold_left <= 400;
    for (int k = 0; k < 30; k++) begin
      send_tick(time_t'(k * 3000));
    end
    drain();
  endtask

  // Hold-off counter
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_left != 0) hold_left <= hold_left - 1;
    end
  end

  // Result side: stall at random, check every accepted word
  initial begin
    fade_word_t want;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        if (pending_words.size() == 0) begin
          $display("%0t: unexpected word color %h changed %b", $time, color_out_o, changed_o);
          mismatch_count++;
        end else begin
          want = pending_words[0];
          pending_words.delete(0);
          if (color_out_o !== want.color) begin
            $display("%0t: color_out expected %h actual %h", $time, want.color, color_out_o);
            mismatch_count++;
          end
          if (changed_o !== want.changed) begin
            $display("%0t: changed expected %b actual %b", $time, want.changed, changed_o);
            mismatch_count++;
          end
        end
      end
      out_stall_i <= (hold_left != 0) || ($urandom_range(99) < stall_pct);
    end
  end

  // Watchdog
  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("testbench: errors");
    $finish;
  end

  // Test sequence
  initial begin
    rst_ni         <= 1'b0;
    cfg_we_i       <= 1'b0;
    cfg_idx_i      <= '0;
    cfg_data_i     <= '0;
    in_valid_i     <= 1'b0;
    current_time_i <= '0;
    reg_start    = '0;
    reg_dur      = '0;
    reg_from     = '0;
    reg_to       = '0;
    reg_pingpong = 1'b0;
    shown_color  = '0;
    rearm('0, '0, '0, '0);
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_idle_after_reset();
    test_linear_fade();
    test_zero_duration();
    test_end_saturation();
    test_ping_pong();
    test_ignored_index();
    test_random_traffic();
    test_input_backpressure();
    repeat (60) @(posedge clk_i);
    if (mismatch_count == 0 && pending_words.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+rtl
rtl/rgbafi_pkg.sv
rtl/rgbafi_lerp.sv
rtl/rgba_fade_interpolator.sv
tb/testbench.sv
